// ===== hdl/rti_pkg.sv =====
// Shared types and constants for the ray/triangle intersection pipeline.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rti_pkg;

  // Input coordinates are signed Q16.16.
  localparam int unsigned COORD_W = 32;
  // Edge and offset vectors are differences of two coordinates.
  localparam int unsigned EDGE_W = COORD_W + 1;

  // Split multiplier: a wide signed operand by a narrow signed operand.
  localparam int unsigned MUL_A_W = 68;
  localparam int unsigned MUL_B_W = 34;
  localparam int unsigned MUL_SPLIT = MUL_A_W / 2;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_LAT = 2;

  // Dot products of a cross product with an edge, offset or direction vector.
  localparam int unsigned NUM_W = 104;

  // Quotient: magnitude bits produced by the divider, and the fraction shift.
  localparam int unsigned QUOT_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned REM_W = NUM_W + QUOT_W;

  localparam int unsigned BARY_W = 17;
  localparam logic [BARY_W-1:0] BARY_ONE = BARY_W'(1 << FRAC_W);

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_T_MIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_T_MAX = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [MUL_A_W-1:0] mula_t;
  typedef logic signed [MUL_B_W-1:0] mulb_t;
  typedef logic signed [MUL_P_W-1:0] mulp_t;
  typedef logic signed [NUM_W-1:0] num_t;

  typedef enum logic [2:0] {
    CAUSE_HIT      = 3'd0,
    CAUSE_PARALLEL = 3'd1,
    CAUSE_B1_OUT   = 3'd2,
    CAUSE_B2_OUT   = 3'd3,
    CAUSE_T_RANGE  = 3'd4
  } cause_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tri_req_t;

  typedef struct packed {
    logic                      hit;
    cause_e                    cause;
    logic signed [COORD_W-1:0] t_hit;
    logic [BARY_W-1:0]         bary1;
    logic [BARY_W-1:0]         bary2;
  } tri_res_t;

endpackage

`default_nettype wire

// ===== hdl/rti_mul.sv =====
// Two-stage signed multiplier built from two half-width partial products.
// Depends on rti_pkg for operand and product widths.
`default_nettype none

module rti_mul (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire rti_pkg::mula_t a_i,
  input  wire rti_pkg::mulb_t b_i,
  output      rti_pkg::mulp_t p_o
);

  logic signed [rti_pkg::MUL_SPLIT:0] a_lo;
  logic signed [rti_pkg::MUL_A_W-rti_pkg::MUL_SPLIT-1:0] a_hi;
  logic signed [rti_pkg::MUL_SPLIT+rti_pkg::MUL_B_W:0] lo_d, lo_q;
  logic signed [rti_pkg::MUL_A_W-rti_pkg::MUL_SPLIT+rti_pkg::MUL_B_W-1:0] hi_d, hi_q;
  rti_pkg::mulp_t p_d, p_q;

  // Low half is taken as unsigned, the high half carries the sign.
  assign a_lo = $signed({1'b0, a_i[rti_pkg::MUL_SPLIT-1:0]});
  assign a_hi = a_i[rti_pkg::MUL_A_W-1:rti_pkg::MUL_SPLIT];
  assign lo_d = a_lo * b_i;
  assign hi_d = a_hi * b_i;
  assign p_d  = (rti_pkg::MUL_P_W'(hi_q) <<< rti_pkg::MUL_SPLIT) + rti_pkg::MUL_P_W'(lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hdl/rti_cross.sv =====
// Cross products s1 = dir x e2 and s2 = d x e1, three register stages.
// Depends on rti_pkg and rti_mul.
`default_nettype none

module rti_cross (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire rti_pkg::coord_t dir_i [3],
  input  wire rti_pkg::edge_t  e1_i [3],
  input  wire rti_pkg::edge_t  e2_i [3],
  input  wire rti_pkg::edge_t  d_i [3],
  output      logic            valid_o,
  output      rti_pkg::mula_t  s1_o [3],
  output      rti_pkg::mula_t  s2_o [3],
  output      rti_pkg::edge_t  e1_o [3],
  output      rti_pkg::edge_t  e2_o [3],
  output      rti_pkg::edge_t  d_o [3]
);

  localparam int unsigned Lat = rti_pkg::MUL_LAT + 1;

  rti_pkg::mula_t op_u [2][3];
  rti_pkg::mulb_t op_v [2][3];
  rti_pkg::mulp_t prod_a [2][3];
  rti_pkg::mulp_t prod_b [2][3];
  rti_pkg::mula_t s_q [2][3];
  rti_pkg::edge_t e1_q [Lat][3];
  rti_pkg::edge_t e2_q [Lat][3];
  rti_pkg::edge_t d_q [Lat][3];
  logic [Lat-1:0] valid_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op_u[0][k] = rti_pkg::MUL_A_W'(dir_i[k]);
      op_v[0][k] = rti_pkg::MUL_B_W'(e2_i[k]);
      op_u[1][k] = rti_pkg::MUL_A_W'(d_i[k]);
      op_v[1][k] = rti_pkg::MUL_B_W'(e1_i[k]);
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_vec
    for (genvar k = 0; k < 3; k++) begin : g_comp
      rti_mul u_mul_a (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (op_u[g][(k+1)%3]),
        .b_i   (op_v[g][(k+2)%3]),
        .p_o   (prod_a[g][k])
      );
      rti_mul u_mul_b (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (op_u[g][(k+2)%3]),
        .b_i   (op_v[g][(k+1)%3]),
        .p_o   (prod_b[g][k])
      );
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          s_q[g][k] <= rti_pkg::MUL_A_W'(prod_a[g][k] - prod_b[g][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q[0] <= e1_i;
      e2_q[0] <= e2_i;
      d_q[0]  <= d_i;
      for (int s = 1; s < Lat; s++) begin
        e1_q[s] <= e1_q[s-1];
        e2_q[s] <= e2_q[s-1];
        d_q[s]  <= d_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Lat-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Lat-1];
  assign s1_o    = s_q[0];
  assign s2_o    = s_q[1];
  assign e1_o    = e1_q[Lat-1];
  assign e2_o    = e2_q[Lat-1];
  assign d_o     = d_q[Lat-1];

endmodule

`default_nettype wire

// ===== hdl/rti_dot.sv =====
// The four dot products den, nb1, nb2 and nt, three register stages.
// Depends on rti_pkg and rti_mul.
`default_nettype none

module rti_dot (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire rti_pkg::coord_t dir_i [3],
  input  wire rti_pkg::mula_t  s1_i [3],
  input  wire rti_pkg::mula_t  s2_i [3],
  input  wire rti_pkg::edge_t  e1_i [3],
  input  wire rti_pkg::edge_t  e2_i [3],
  input  wire rti_pkg::edge_t  d_i [3],
  output      logic            valid_o,
  output      rti_pkg::num_t   den_o,
  output      rti_pkg::num_t   nb1_o,
  output      rti_pkg::num_t   nb2_o,
  output      rti_pkg::num_t   nt_o
);

  localparam int unsigned Lat = rti_pkg::MUL_LAT + 1;

  // Group order: den = s1.e1, nb1 = s1.d, nb2 = s2.dir, nt = s2.e2.
  rti_pkg::mula_t op_a [4][3];
  rti_pkg::mulb_t op_b [4][3];
  rti_pkg::mulp_t prod [4][3];
  rti_pkg::num_t  acc_q [4];
  logic [Lat-1:0] valid_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op_a[0][k] = s1_i[k];
      op_b[0][k] = rti_pkg::MUL_B_W'(e1_i[k]);
      op_a[1][k] = s1_i[k];
      op_b[1][k] = rti_pkg::MUL_B_W'(d_i[k]);
      op_a[2][k] = s2_i[k];
      op_b[2][k] = rti_pkg::MUL_B_W'(dir_i[k]);
      op_a[3][k] = s2_i[k];
      op_b[3][k] = rti_pkg::MUL_B_W'(e2_i[k]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_term
      rti_mul u_mul (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (op_a[g][k]),
        .b_i   (op_b[g][k]),
        .p_o   (prod[g][k])
      );
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[g] <= rti_pkg::NUM_W'(prod[g][0]) + rti_pkg::NUM_W'(prod[g][1])
                  + rti_pkg::NUM_W'(prod[g][2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Lat-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Lat-1];
  assign den_o   = acc_q[0];
  assign nb1_o   = acc_q[1];
  assign nb2_o   = acc_q[2];
  assign nt_o    = acc_q[3];

endmodule

`default_nettype wire

// ===== hdl/rti_div.sv =====
// Pipelined restoring divider: |num| * 2^16 / |den|, one quotient bit per stage.
// Reports sign, divisor zero and overflow beyond the kept magnitude bits.
// Depends on rti_pkg.
`default_nettype none

module rti_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire rti_pkg::num_t               num_i,
  input  wire rti_pkg::num_t               den_i,
  output      logic                        valid_o,
  output      logic                        neg_o,
  output      logic                        dz_o,
  output      logic                        ovf_o,
  output      logic [rti_pkg::QUOT_W-1:0]  mag_o
);

  localparam int unsigned Stages = rti_pkg::QUOT_W + 2;

  // Stage one: signs and magnitudes.
  logic [rti_pkg::NUM_W-1:0] nmag_q, dmag_a_q;
  logic neg_a_q, dz_a_q;
  // Stage two onward: remainder, quotient and side flags.
  logic [rti_pkg::REM_W-1:0]  rem_q [rti_pkg::QUOT_W+1];
  logic [rti_pkg::QUOT_W-1:0] q_q   [rti_pkg::QUOT_W+1];
  logic [rti_pkg::NUM_W-1:0]  dmag_q [rti_pkg::QUOT_W+1];
  logic [rti_pkg::QUOT_W:0]   neg_q, dz_q, ovf_q;
  logic [Stages-1:0] valid_q;
  logic [rti_pkg::REM_W-1:0] rem0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q  <= num_i[rti_pkg::NUM_W-1] ^ den_i[rti_pkg::NUM_W-1];
      dz_a_q   <= (den_i == '0);
      nmag_q   <= num_i[rti_pkg::NUM_W-1] ? -num_i : num_i;
      dmag_a_q <= den_i[rti_pkg::NUM_W-1] ? -den_i : den_i;
    end
  end

  assign rem0 = rti_pkg::REM_W'(nmag_q) << rti_pkg::FRAC_W;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem0;
      q_q[0]    <= '0;
      dmag_q[0] <= dmag_a_q;
      neg_q[0]  <= neg_a_q;
      dz_q[0]   <= dz_a_q;
      ovf_q[0]  <= rem0 >= (rti_pkg::REM_W'(dmag_a_q) << rti_pkg::QUOT_W);
    end
  end

  for (genvar s = 0; s < rti_pkg::QUOT_W; s++) begin : g_bit
    localparam int unsigned Bit = rti_pkg::QUOT_W - 1 - s;
    logic [rti_pkg::REM_W-1:0] trial;
    logic take;
    assign trial = rti_pkg::REM_W'(dmag_q[s]) << Bit;
    assign take  = rem_q[s] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? rem_q[s] - trial : rem_q[s];
        q_q[s+1]    <= q_q[s] | (rti_pkg::QUOT_W'(take) << Bit);
        dmag_q[s+1] <= dmag_q[s];
        neg_q[s+1]  <= neg_q[s];
        dz_q[s+1]   <= dz_q[s];
        ovf_q[s+1]  <= ovf_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Stages-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign neg_o   = neg_q[rti_pkg::QUOT_W];
  assign dz_o    = dz_q[rti_pkg::QUOT_W];
  assign ovf_o   = ovf_q[rti_pkg::QUOT_W];
  assign mag_o   = q_q[rti_pkg::QUOT_W];

endmodule

`default_nettype wire

// ===== hdl/ray_triangle_intersect.sv =====
// Moller-Trumbore ray/triangle test. The ray (origin, direction, t_min, t_max)
// sits in eight configuration registers written through the cfg port, which
// is always ready; write them only while no request is in flight. Triangles
// stream in on the tri channel, one request per clock unless stalled, and
// each produces exactly one result in order. From acceptance to the result
// register a request passes one edge stage, three for the cross products,
// three for the dot products, two divider setup stages, 32 quotient-bit
// stages and the classification/output register. The throughput of one
// request per cycle is set by the fully pipelined multipliers and dividers.
// The whole pipeline advances together and halts only while a result waits
// under res_stall_i, so tri_stall_o is high exactly then. Misses report
// hit=0, a cause code and zeroed distance and barycentrics.
// Depends on rti_pkg, rti_cross, rti_dot, rti_div and rti_mul.
`default_nettype none

module ray_triangle_intersect (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [rti_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [rti_pkg::COORD_W-1:0]        cfg_data_i,
  input  wire logic                               tri_valid_i,
  output      logic                               tri_stall_o,
  input  wire rti_pkg::tri_req_t                  tri_i,
  output      logic                               res_valid_o,
  input  wire logic                               res_stall_i,
  output      rti_pkg::tri_res_t                  res_o
);

  rti_pkg::coord_t origin_q [3];
  rti_pkg::coord_t dir_q [3];
  rti_pkg::coord_t t_min_q, t_max_q;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= rti_pkg::COORD_W'(1 << rti_pkg::FRAC_W);
      t_min_q     <= '0;
      t_max_q     <= {1'b0, {(rti_pkg::COORD_W-1){1'b1}}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rti_pkg::CFG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        rti_pkg::CFG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        rti_pkg::CFG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        rti_pkg::CFG_DIR_X:    dir_q[0]    <= cfg_data_i;
        rti_pkg::CFG_DIR_Y:    dir_q[1]    <= cfg_data_i;
        rti_pkg::CFG_DIR_Z:    dir_q[2]    <= cfg_data_i;
        rti_pkg::CFG_T_MIN:    t_min_q     <= cfg_data_i;
        rti_pkg::CFG_T_MAX:    t_max_q     <= cfg_data_i;
        default:               t_max_q     <= t_max_q;
      endcase
    end
  end

  // The pipeline moves as one unit unless the finished result is blocked.
  logic en;
  logic out_valid_q;
  assign en          = !(out_valid_q && res_stall_i);
  assign tri_stall_o = !en;

  // Edge stage: e1 = B - A, e2 = C - A, d = origin - A.
  rti_pkg::coord_t va [3], vb [3], vc [3];
  rti_pkg::edge_t  e1_q [3], e2_q [3], d_q [3];
  logic            v1_q;

  assign va = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign vb = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign vc = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= rti_pkg::EDGE_W'(vb[k]) - rti_pkg::EDGE_W'(va[k]);
        e2_q[k] <= rti_pkg::EDGE_W'(vc[k]) - rti_pkg::EDGE_W'(va[k]);
        d_q[k]  <= rti_pkg::EDGE_W'(origin_q[k]) - rti_pkg::EDGE_W'(va[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= tri_valid_i;
    end
  end

  // Cross products.
  logic           cr_valid;
  rti_pkg::mula_t s1 [3], s2 [3];
  rti_pkg::edge_t cr_e1 [3], cr_e2 [3], cr_d [3];

  rti_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .dir_i   (dir_q),
    .e1_i    (e1_q),
    .e2_i    (e2_q),
    .d_i     (d_q),
    .valid_o (cr_valid),
    .s1_o    (s1),
    .s2_o    (s2),
    .e1_o    (cr_e1),
    .e2_o    (cr_e2),
    .d_o     (cr_d)
  );

  // Dot products.
  logic          dot_valid;
  rti_pkg::num_t den, nb1, nb2, nt;

  rti_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cr_valid),
    .dir_i   (dir_q),
    .s1_i    (s1),
    .s2_i    (s2),
    .e1_i    (cr_e1),
    .e2_i    (cr_e2),
    .d_i     (cr_d),
    .valid_o (dot_valid),
    .den_o   (den),
    .nb1_o   (nb1),
    .nb2_o   (nb2),
    .nt_o    (nt)
  );

  // Three quotients share the same divisor; the b1 unit also reports
  // the divisor-zero flag and the request valid for all three.
  logic                       div_valid, dz;
  logic                       neg1, neg2, negt, ovf1, ovf2, ovft;
  logic [rti_pkg::QUOT_W-1:0] mag1, mag2, magt;

  rti_div u_div_b1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .num_i   (nb1),
    .den_i   (den),
    .valid_o (div_valid),
    .neg_o   (neg1),
    .dz_o    (dz),
    .ovf_o   (ovf1),
    .mag_o   (mag1)
  );

  rti_div u_div_b2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .num_i   (nb2),
    .den_i   (den),
    .valid_o (),
    .neg_o   (neg2),
    .dz_o    (),
    .ovf_o   (ovf2),
    .mag_o   (mag2)
  );

  rti_div u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .num_i   (nt),
    .den_i   (den),
    .valid_o (),
    .neg_o   (negt),
    .dz_o    (),
    .ovf_o   (ovft),
    .mag_o   (magt)
  );

  // Classification. An overflowed quotient is beyond every accepted range:
  // a barycentric past one either way, a distance past any 32-bit bound.
  localparam int unsigned TW = rti_pkg::QUOT_W + 2;
  logic signed [TW-1:0] t_val, t_lo, t_hi;
  logic b1_out, b2_out, t_out;
  rti_pkg::tri_res_t res_d, res_q;

  assign t_val = negt ? -$signed({2'b00, magt}) : $signed({2'b00, magt});
  assign t_lo  = TW'(t_min_q);
  assign t_hi  = TW'(t_max_q);

  assign b1_out = ovf1 || (neg1 && (mag1 != '0))
                || (mag1 > rti_pkg::QUOT_W'(rti_pkg::BARY_ONE));
  assign b2_out = ovf2 || (neg2 && (mag2 != '0))
                || ((rti_pkg::QUOT_W'(mag1) + mag2) > rti_pkg::QUOT_W'(rti_pkg::BARY_ONE))
                || (mag2 > rti_pkg::QUOT_W'(rti_pkg::BARY_ONE));
  assign t_out  = ovft || (t_val < t_lo) || (t_val > t_hi);

  always_comb begin
    res_d = '0;
    priority if (dz) begin
      res_d.cause = rti_pkg::CAUSE_PARALLEL;
    end else if (b1_out) begin
      res_d.cause = rti_pkg::CAUSE_B1_OUT;
    end else if (b2_out) begin
      res_d.cause = rti_pkg::CAUSE_B2_OUT;
    end else if (t_out) begin
      res_d.cause = rti_pkg::CAUSE_T_RANGE;
    end else begin
      res_d.hit   = 1'b1;
      res_d.cause = rti_pkg::CAUSE_HIT;
      res_d.t_hit = t_val[rti_pkg::COORD_W-1:0];
      res_d.bary1 = mag1[rti_pkg::BARY_W-1:0];
      res_d.bary2 = mag2[rti_pkg::BARY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/rti_checker.sv =====
// Port-level checks for ray_triangle_intersect, attached by bind.
// Depends on rti_pkg and the top level's port list.
`default_nettype none

module rti_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [rti_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [rti_pkg::COORD_W-1:0]   cfg_data_i,
  input wire logic                          tri_valid_i,
  input wire logic                          tri_stall_o,
  input wire rti_pkg::tri_req_t             tri_i,
  input wire logic                          res_valid_o,
  input wire logic                          res_stall_i,
  input wire rti_pkg::tri_res_t             res_o
);

  // A blocked result stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o))
    else $error("result changed while stalled");

  // Input is held off only while a finished result is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_stall_o |-> res_valid_o && res_stall_i)
    else $error("input stalled without a blocked result");

  // The hit flag agrees with the cause code.
  a_hit_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.hit == (res_o.cause == rti_pkg::CAUSE_HIT)))
    else $error("hit flag and cause disagree");

  // A hit lies inside the triangle.
  a_bary_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.hit
      |-> (18'(res_o.bary1) + 18'(res_o.bary2)) <= 18'(rti_pkg::BARY_ONE))
    else $error("barycentrics of a hit sum past one");

  // A miss carries zeroed payload.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.hit
      |-> res_o.t_hit == '0 && res_o.bary1 == '0 && res_o.bary2 == '0)
    else $error("miss with nonzero payload");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the ray/triangle intersection pipeline.
// Depends on rti_pkg and the ray_triangle_intersect top level only.
`default_nettype none

// Holds the ray registers as seen by the block. For each accepted triangle
// request it computes the expected intersection result and queues it. Results
// from the block are then checked against that queue in order.
class hit_scoreboard;
  typedef logic signed [127:0] wide_t;

  rti_pkg::coord_t ray_reg [8];
  rti_pkg::tri_res_t hits_due [$];
  int unsigned errors;

  function new();
    foreach (ray_reg[i]) ray_reg[i] = '0;
    ray_reg[rti_pkg::CFG_DIR_Z] = 32'sd65536;
    ray_reg[rti_pkg::CFG_T_MAX] = 32'sh7FFFFFFF;
    errors = 0;
  endfunction

  function void write_reg(logic [rti_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    ray_reg[idx] = val;
  endfunction

  // num * 2^16 / den, truncated toward zero, magnitude clamped to 2^62.
  function automatic logic signed [63:0] fixed_div(wide_t num, wide_t den);
    logic [127:0] n, d, q;
    logic signed [63:0] mag;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << 16) / d;
    mag = (q > 128'h4000_0000_0000_0000) ? 64'sh4000_0000_0000_0000 : q[63:0];
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic rti_pkg::tri_res_t predict_hit(rti_pkg::tri_req_t r);
    wide_t a [3], b [3], c [3], e1 [3], e2 [3], d [3], dv [3], s1 [3], s2 [3];
    wide_t den;
    logic signed [63:0] b1, b2, t;
    rti_pkg::tri_res_t res;
    a[0] = r.a_x; a[1] = r.a_y; a[2] = r.a_z;
    b[0] = r.b_x; b[1] = r.b_y; b[2] = r.b_z;
    c[0] = r.c_x; c[1] = r.c_y; c[2] = r.c_z;
    dv[0] = ray_reg[rti_pkg::CFG_DIR_X];
    dv[1] = ray_reg[rti_pkg::CFG_DIR_Y];
    dv[2] = ray_reg[rti_pkg::CFG_DIR_Z];
    d[0] = ray_reg[rti_pkg::CFG_ORIGIN_X];
    d[1] = ray_reg[rti_pkg::CFG_ORIGIN_Y];
    d[2] = ray_reg[rti_pkg::CFG_ORIGIN_Z];
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      d[i] = d[i] - a[i];
    end
    s1[0] = dv[1] * e2[2] - dv[2] * e2[1];
    s1[1] = dv[2] * e2[0] - dv[0] * e2[2];
    s1[2] = dv[0] * e2[1] - dv[1] * e2[0];
    s2[0] = d[1] * e1[2] - d[2] * e1[1];
    s2[1] = d[2] * e1[0] - d[0] * e1[2];
    s2[2] = d[0] * e1[1] - d[1] * e1[0];
    den = s1[0] * e1[0] + s1[1] * e1[1] + s1[2] * e1[2];
    res = '0;
    res.cause = rti_pkg::CAUSE_HIT;
    if (den == 0) begin
      res.cause = rti_pkg::CAUSE_PARALLEL;
    end else begin
      b1 = fixed_div(s1[0] * d[0] + s1[1] * d[1] + s1[2] * d[2], den);
      b2 = fixed_div(s2[0] * dv[0] + s2[1] * dv[1] + s2[2] * dv[2], den);
      t = fixed_div(s2[0] * e2[0] + s2[1] * e2[1] + s2[2] * e2[2], den);
      if (b1 < 0 || b1 > 65536) begin
        res.cause = rti_pkg::CAUSE_B1_OUT;
      end else if (b2 < 0 || b1 + b2 > 65536) begin
        res.cause = rti_pkg::CAUSE_B2_OUT;
      end else if (t < 64'(ray_reg[rti_pkg::CFG_T_MIN]) ||
                   t > 64'(ray_reg[rti_pkg::CFG_T_MAX])) begin
        res.cause = rti_pkg::CAUSE_T_RANGE;
      end else begin
        res.hit = 1'b1;
        res.t_hit = t[31:0];
        res.bary1 = b1[16:0];
        res.bary2 = b2[16:0];
      end
    end
    return res;
  endfunction

  function void note_request(rti_pkg::tri_req_t r);
    hits_due.push_back(predict_hit(r));
  endfunction

  function void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(rti_pkg::tri_res_t got);
    rti_pkg::tri_res_t want;
    if (hits_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = hits_due.pop_front();
    field_check("hit", 32'(want.hit), 32'(got.hit));
    field_check("cause", 32'(want.cause), 32'(got.cause));
    field_check("t_hit", want.t_hit, got.t_hit);
    field_check("bary1", 32'(want.bary1), 32'(got.bary1));
    field_check("bary2", 32'(want.bary2), 32'(got.bary2));
  endfunction
endclass

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rti_pkg::COORD_W-1:0] cfg_data_i = '0;
  logic tri_valid_i = 1'b0;
  logic tri_stall_o;
  rti_pkg::tri_req_t tri_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  rti_pkg::tri_res_t res_o;

  hit_scoreboard sb = new();

  // Sender and receiver pacing. With no_idle set, neither side inserts gaps.
  bit no_idle = 1'b0;
  // A request for the receiver to hold off long enough to back up the pipe.
  bit hold_off_req = 1'b0;

  // Current ray, kept here to aim generated triangles at it.
  rti_pkg::coord_t ray [8];

  ray_triangle_intersect i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .tri_valid_i, .tri_stall_o, .tri_i, .res_valid_o, .res_stall_i, .res_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int signed rnd_span(int signed lim);
    return $signed($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // All checking is done on sampled values at the clock edge, so it sees
  // exactly what the block sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (tri_valid_i && !tri_stall_o) sb.note_request(tri_i);
      if (res_valid_o && !res_stall_i) sb.check_result(res_o);
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here in cycles.
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        res_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      n = idle_len();
      if (n > 0) begin
        res_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      res_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [rti_pkg::CFG_IDX_W-1:0] idx, rti_pkg::coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ray[idx] = val;
  endtask

  // Registers change only with the pipeline empty: the sender stops, all
  // results are in and the pipe depth has drained as well.
  task automatic drain();
    tri_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.hits_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic load_ray(rti_pkg::coord_t ox, rti_pkg::coord_t oy, rti_pkg::coord_t oz,
                          rti_pkg::coord_t dx, rti_pkg::coord_t dy, rti_pkg::coord_t dz,
                          rti_pkg::coord_t tmin, rti_pkg::coord_t tmax);
    drain();
    write_reg(rti_pkg::CFG_ORIGIN_X, ox);
    write_reg(rti_pkg::CFG_ORIGIN_Y, oy);
    write_reg(rti_pkg::CFG_ORIGIN_Z, oz);
    write_reg(rti_pkg::CFG_DIR_X, dx);
    write_reg(rti_pkg::CFG_DIR_Y, dy);
    write_reg(rti_pkg::CFG_DIR_Z, dz);
    write_reg(rti_pkg::CFG_T_MIN, tmin);
    write_reg(rti_pkg::CFG_T_MAX, tmax);
    @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back requests; it drops only for a gap.
  task automatic send_tri(rti_pkg::tri_req_t r);
    int unsigned n;
    tri_valid_i <= 1'b1;
    tri_i <= r;
    do @(posedge clk_i); while (tri_stall_o);
    n = idle_len();
    if (n > 0) begin
      tri_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_verts(int signed ax, int signed ay, int signed az, int signed bx,
                            int signed by, int signed bz, int signed cx, int signed cy,
                            int signed cz);
    rti_pkg::tri_req_t r;
    r = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    send_tri(r);
  endtask

  // A triangle built around a point on the ray, so that hits are common and
  // near-misses on every edge show up as well.
  task automatic send_aimed();
    longint signed p [3];
    longint signed tt;
    int signed span;
    rti_pkg::tri_req_t r;
    tt = longint'($urandom_range(0, 1 << 20));
    span = 1 << $urandom_range(4, 20);
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'(ray[rti_pkg::CFG_ORIGIN_X + i])
           + ((longint'(ray[rti_pkg::CFG_DIR_X + i]) * tt) >>> 16);
    end
    r.a_x = 32'(p[0] + rnd_span(span)); r.a_y = 32'(p[1] + rnd_span(span));
    r.a_z = 32'(p[2] + rnd_span(span));
    r.b_x = 32'(p[0] + rnd_span(span)); r.b_y = 32'(p[1] + rnd_span(span));
    r.b_z = 32'(p[2] + rnd_span(span));
    r.c_x = 32'(p[0] + rnd_span(span)); r.c_y = 32'(p[1] + rnd_span(span));
    r.c_z = 32'(p[2] + rnd_span(span));
    send_tri(r);
  endtask

  task automatic send_random(int unsigned count);
    rti_pkg::tri_req_t r;
    int unsigned kind;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_aimed();
      end else begin
        for (int i = 0; i < 9; i++) r[32*i +: 32] = $urandom();
        // A collapsed edge gives a zero divisor.
        if (kind == 8) {r.b_x, r.b_y, r.b_z} = {r.a_x, r.a_y, r.a_z};
        send_tri(r);
      end
    end
  endtask

  task automatic random_ray(rti_pkg::coord_t tmin, rti_pkg::coord_t tmax);
    load_ray(rnd_span(1 << 20), rnd_span(1 << 20), rnd_span(1 << 20),
             rnd_span(1 << 17), rnd_span(1 << 17), rnd_span(1 << 17), tmin, tmax);
  endtask

  initial begin
    localparam int signed ONE = 65536;
    foreach (ray[i]) ray[i] = '0;
    ray[rti_pkg::CFG_DIR_Z] = ONE;
    ray[rti_pkg::CFG_T_MAX] = 32'sh7FFFFFFF;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the reset ray pointing down +z from the origin.
    no_idle = 1'b1;
    send_verts(-ONE, -ONE, 2 * ONE, 2 * ONE, -ONE, 2 * ONE, -ONE, 2 * ONE, 2 * ONE);
    send_verts(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_verts(ONE, -ONE, 2 * ONE, 4 * ONE, -ONE, 2 * ONE, ONE, 2 * ONE, 2 * ONE);
    send_verts(-ONE, ONE, 2 * ONE, 2 * ONE, ONE, 2 * ONE, -ONE, 4 * ONE, 2 * ONE);
    send_verts(-ONE, -ONE, -2 * ONE, 2 * ONE, -ONE, -2 * ONE, -ONE, 2 * ONE, -2 * ONE);
    send_verts(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE);
    send_verts(-ONE, -ONE, ONE, ONE, ONE, ONE, -ONE, -ONE, ONE);
    send_verts(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_verts(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_verts(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
               32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh7FFFFFFF);
    // A window of a single point: a hit exactly on it and a miss just past it.
    load_ray(0, 0, 0, 0, 0, ONE, 2 * ONE, 2 * ONE);
    send_verts(-ONE, -ONE, 2 * ONE, 2 * ONE, -ONE, 2 * ONE, -ONE, 2 * ONE, 2 * ONE);
    send_verts(-ONE, -ONE, 3 * ONE, 2 * ONE, -ONE, 3 * ONE, -ONE, 2 * ONE, 3 * ONE);
    // Extreme ray registers.
    load_ray(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
             32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
    send_random(80);
    no_idle = 1'b0;

    // Random part over several ray settings.
    random_ray(0, 32'sh7FFFFFFF);
    send_random(50);
    // Keep the sender busy while the receiver holds off, so the pipe fills.
    no_idle = 1'b1;
    hold_off_req = 1'b1;
    send_random(150);
    no_idle = 1'b0;
    random_ray(32'sh80000000, 32'sh7FFFFFFF);
    send_random(200);
    random_ray(ONE, 4 * ONE);
    send_random(200);
    // Empty window: t_min above t_max rejects everything.
    random_ray(4 * ONE, ONE);
    send_random(100);
    load_ray(0, 0, 0, 0, 0, ONE, 0, 32'sh7FFFFFFF);
    no_idle = 1'b1;
    send_random(100);
    no_idle = 1'b0;
    random_ray(32'sh80000000, 0);
    send_random(100);
    tri_valid_i <= 1'b0;

    drain();
    if (sb.errors == 0 && sb.hits_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire
